### sv/dtc_pkg.sv
// shared types, widths and constants of the depth to color pixel map
`timescale 1ns / 1ps
`default_nettype none

package dtc_pkg;

  // frame of the color camera
  localparam int COLOR_WIDTH  = 1920;
  localparam int COLOR_HEIGHT = 1080;

  // field widths
  localparam int COL_W   = 9;
  localparam int MM_W    = 16;
  localparam int SCALE_W = 20;
  localparam int OFF_W   = 28;
  localparam int NUM_W   = 32;
  localparam int PIX_W   = 11;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = SCALE_W + COL_W;
  localparam int SX_W    = NUM_W + 3;
  localparam int SY_W    = PROD_W + 2;

  // divider: quotient bits resolved per stage
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = NUM_W / DIV_BITS;

  // accept edge to result strobe: scale stage, divider, sum stage, output stage
  localparam int LATENCY = DIV_STAGES + 3;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_SCALE_X   = 3'd0,
    REG_OFFSET_X  = 3'd1,
    REG_SCALE_Y   = 3'd2,
    REG_OFFSET_Y  = 3'd3,
    REG_SHIFT_NUM = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        [SCALE_W-1:0] scale_x;
    logic signed [OFF_W-1:0]   offset_x;
    logic        [SCALE_W-1:0] scale_y;
    logic signed [OFF_W-1:0]   offset_y;
    logic        [NUM_W-1:0]   shift_num;
  } cfg_t;

  // what travels beside the divider
  typedef struct packed {
    logic              nz;
    logic [PROD_W-1:0] px;
    logic [PROD_W-1:0] py;
  } side_t;

  typedef struct packed {
    logic [MM_W-1:0]  rem;
    logic [NUM_W-1:0] num;
    logic [MM_W-1:0]  den;
    side_t            side;
  } div_word_t;

endpackage

`default_nettype wire

### sv/depth_to_color_pixel_map.sv
// top level of the depth to color pixel map
`timescale 1ns / 1ps
`default_nettype none

// maps one depth pixel (column, row, depth in mm) to a color camera pixel:
// color_x = scale_x*col + offset_x + shift_num/depth, color_y = scale_y*row + offset_y,
// each an exact q.16 sum truncated toward zero, so sums in (-1,0) land on pixel zero.
// one word is taken per clock whenever start is high and busy is low; busy is high
// only while rst is asserted. every word gives exactly one result word, strobed by
// done for one cycle, after one scaling stage, eight stages of the 32-bit by
// 16-bit divider at four quotient bits each, a sum stage and the check/output
// stage. the receiver cannot stall, so nothing is held back.
// zero depth and pixels outside the color frame give hit low with both coordinates
// zero. columns and rows beyond the depth frame are mapped by the same formula.
// registers sit on the apb-style port at 4*index: scale_x, offset_x, scale_y,
// offset_y, shift_num; write them only while no word is in flight.

module depth_to_color_pixel_map (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // pixel command
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [dtc_pkg::COL_W-1:0]     depth_col,
  input  wire logic [dtc_pkg::COL_W-1:0]     depth_row,
  input  wire logic [dtc_pkg::MM_W-1:0]      depth_mm,
  // result word
  output logic                               done,
  output logic                               hit,
  output logic      [dtc_pkg::PIX_W-1:0]     color_x,
  output logic      [dtc_pkg::PIX_W-1:0]     color_y,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dtc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [dtc_pkg::DATA_W-1:0]    pwdata,
  output logic      [dtc_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);

  dtc_pkg::cfg_t   cfg;

  logic                          acc;
  logic                          sc_vld;
  logic [dtc_pkg::MM_W-1:0]      sc_den;
  dtc_pkg::side_t                sc_side;
  logic                          dv_vld;
  logic [dtc_pkg::NUM_W-1:0]     dv_quo;
  dtc_pkg::side_t                dv_side;

  // the pipeline never backs up; only reset turns words away
  assign busy = rst;
  assign acc  = start && !busy;

  dtc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // focal products, registered before the divider
  dtc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (acc),
    .depth_col (depth_col),
    .depth_row (depth_row),
    .depth_mm  (depth_mm),
    .cfg       (cfg),
    .out_vld   (sc_vld),
    .out_den   (sc_den),
    .out_side  (sc_side)
  );

  // baseline shift term shift_num/depth; zero depth is flagged and ignored later
  dtc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sc_vld),
    .in_num   (cfg.shift_num),
    .in_den   (sc_den),
    .in_side  (sc_side),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  // sums, truncation and frame check
  dtc_place u_place (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (dv_vld),
    .in_quo  (dv_quo),
    .in_side (dv_side),
    .cfg     (cfg),
    .done    (done),
    .hit     (hit),
    .color_x (color_x),
    .color_y (color_y)
  );

endmodule

`default_nettype wire

### sv/dtc_cfg.sv
// configuration registers behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none

module dtc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dtc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [dtc_pkg::DATA_W-1:0]   pwdata,
  output logic      [dtc_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output dtc_pkg::cfg_t                     cfg
);

  dtc_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = dtc_pkg::reg_idx_t'(paddr[dtc_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_x   <= dtc_pkg::SCALE_W'(194080);
      cfg.offset_x  <= 28'sd12901600;
      cfg.scale_y   <= dtc_pkg::SCALE_W'(194080);
      cfg.offset_y  <= -28'sd5182000;
      cfg.shift_num <= 32'd3842185626;
    end else if (wr) begin
      unique case (idx)
        dtc_pkg::REG_SCALE_X:   cfg.scale_x   <= pwdata[dtc_pkg::SCALE_W-1:0];
        dtc_pkg::REG_OFFSET_X:  cfg.offset_x  <= pwdata[dtc_pkg::OFF_W-1:0];
        dtc_pkg::REG_SCALE_Y:   cfg.scale_y   <= pwdata[dtc_pkg::SCALE_W-1:0];
        dtc_pkg::REG_OFFSET_Y:  cfg.offset_y  <= pwdata[dtc_pkg::OFF_W-1:0];
        dtc_pkg::REG_SHIFT_NUM: cfg.shift_num <= pwdata[dtc_pkg::NUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dtc_pkg::REG_SCALE_X:
        prdata = {{(dtc_pkg::DATA_W-dtc_pkg::SCALE_W){1'b0}}, cfg.scale_x};
      dtc_pkg::REG_OFFSET_X:
        prdata = {{(dtc_pkg::DATA_W-dtc_pkg::OFF_W){cfg.offset_x[dtc_pkg::OFF_W-1]}},
                  cfg.offset_x};
      dtc_pkg::REG_SCALE_Y:
        prdata = {{(dtc_pkg::DATA_W-dtc_pkg::SCALE_W){1'b0}}, cfg.scale_y};
      dtc_pkg::REG_OFFSET_Y:
        prdata = {{(dtc_pkg::DATA_W-dtc_pkg::OFF_W){cfg.offset_y[dtc_pkg::OFF_W-1]}},
                  cfg.offset_y};
      dtc_pkg::REG_SHIFT_NUM:
        prdata = cfg.shift_num;
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/dtc_scale.sv
// entry stage: focal scaling products and depth capture
`timescale 1ns / 1ps
`default_nettype none

module dtc_scale (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_vld,
  input  wire logic [dtc_pkg::COL_W-1:0]     depth_col,
  input  wire logic [dtc_pkg::COL_W-1:0]     depth_row,
  input  wire logic [dtc_pkg::MM_W-1:0]      depth_mm,
  input  wire dtc_pkg::cfg_t                 cfg,
  output logic                               out_vld,
  output logic      [dtc_pkg::MM_W-1:0]      out_den,
  output dtc_pkg::side_t                     out_side
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_den     <= depth_mm;
    out_side.nz <= |depth_mm;
    out_side.px <= dtc_pkg::PROD_W'(cfg.scale_x) * dtc_pkg::PROD_W'(depth_col);
    out_side.py <= dtc_pkg::PROD_W'(cfg.scale_y) * dtc_pkg::PROD_W'(depth_row);
  end

endmodule

`default_nettype wire

### sv/dtc_div.sv
// pipelined restoring divider, a few quotient bits per stage
`timescale 1ns / 1ps
`default_nettype none

module dtc_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_vld,
  input  wire logic [dtc_pkg::NUM_W-1:0]     in_num,
  input  wire logic [dtc_pkg::MM_W-1:0]      in_den,
  input  wire dtc_pkg::side_t                in_side,
  output logic                               out_vld,
  output logic      [dtc_pkg::NUM_W-1:0]     out_quo,
  output dtc_pkg::side_t                     out_side
);

  logic               vld  [dtc_pkg::DIV_STAGES];
  dtc_pkg::div_word_t word [dtc_pkg::DIV_STAGES];

  for (genvar g = 0; g < dtc_pkg::DIV_STAGES; g++) begin : g_stage
    dtc_pkg::div_word_t cur;
    dtc_pkg::div_word_t nxt;
    logic               vin;

    if (g == 0) begin : g_first
      assign vin       = in_vld;
      assign cur.rem   = '0;
      assign cur.num   = in_num;
      assign cur.den   = in_den;
      assign cur.side  = in_side;
    end else begin : g_rest
      assign vin = vld[g-1];
      assign cur = word[g-1];
    end

    // the quotient shifts in from the bottom of num as dividend bits leave the top
    always_comb begin
      logic [dtc_pkg::MM_W:0] t;
      nxt = cur;
      for (int k = 0; k < dtc_pkg::DIV_BITS; k++) begin
        t       = {nxt.rem, nxt.num[dtc_pkg::NUM_W-1]};
        nxt.num = {nxt.num[dtc_pkg::NUM_W-2:0], 1'b0};
        if (t >= {1'b0, nxt.den}) begin
          nxt.rem    = dtc_pkg::MM_W'(t - {1'b0, nxt.den});
          nxt.num[0] = 1'b1;
        end else begin
          nxt.rem = t[dtc_pkg::MM_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      word[g] <= nxt;
    end
  end

  assign out_vld  = vld[dtc_pkg::DIV_STAGES-1];
  assign out_quo  = word[dtc_pkg::DIV_STAGES-1].num;
  assign out_side = word[dtc_pkg::DIV_STAGES-1].side;

endmodule

`default_nettype wire

### sv/dtc_place.sv
// coordinate sums, truncation toward zero and frame check
`timescale 1ns / 1ps
`default_nettype none

module dtc_place (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_vld,
  input  wire logic [dtc_pkg::NUM_W-1:0]     in_quo,
  input  wire dtc_pkg::side_t                in_side,
  input  wire dtc_pkg::cfg_t                 cfg,
  output logic                               done,
  output logic                               hit,
  output logic      [dtc_pkg::PIX_W-1:0]     color_x,
  output logic      [dtc_pkg::PIX_W-1:0]     color_y
);

  localparam int XI_W = dtc_pkg::SX_W - dtc_pkg::FRAC_W;
  localparam int YI_W = dtc_pkg::SY_W - dtc_pkg::FRAC_W;

  // sum stage
  logic                             s_vld;
  logic                             s_nz;
  logic signed [dtc_pkg::SX_W-1:0]  sx;
  logic signed [dtc_pkg::SY_W-1:0]  sy;
  logic signed [dtc_pkg::SX_W-1:0]  sx_next;
  logic signed [dtc_pkg::SY_W-1:0]  sy_next;

  assign sx_next =
      $signed({{(dtc_pkg::SX_W-dtc_pkg::PROD_W){1'b0}}, in_side.px})
    + $signed({{(dtc_pkg::SX_W-dtc_pkg::OFF_W){cfg.offset_x[dtc_pkg::OFF_W-1]}},
               cfg.offset_x})
    + $signed({{(dtc_pkg::SX_W-dtc_pkg::NUM_W){1'b0}}, in_quo});
  assign sy_next =
      $signed({{(dtc_pkg::SY_W-dtc_pkg::PROD_W){1'b0}}, in_side.py})
    + $signed({{(dtc_pkg::SY_W-dtc_pkg::OFF_W){cfg.offset_y[dtc_pkg::OFF_W-1]}},
               cfg.offset_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else begin
      s_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s_nz <= in_side.nz;
    sx   <= sx_next;
    sy   <= sy_next;
  end

  // check stage: a negative sum above -1.0 truncates to pixel zero
  logic [XI_W-1:0] xi;
  logic [YI_W-1:0] yi;
  logic            x_neg, y_neg, x_in, y_in, hit_next;

  assign xi    = sx[dtc_pkg::SX_W-1:dtc_pkg::FRAC_W];
  assign yi    = sy[dtc_pkg::SY_W-1:dtc_pkg::FRAC_W];
  assign x_neg = sx[dtc_pkg::SX_W-1];
  assign y_neg = sy[dtc_pkg::SY_W-1];
  assign x_in  = x_neg ? (&xi && |sx[dtc_pkg::FRAC_W-1:0])
                       : (xi < XI_W'(dtc_pkg::COLOR_WIDTH));
  assign y_in  = y_neg ? (&yi && |sy[dtc_pkg::FRAC_W-1:0])
                       : (yi < YI_W'(dtc_pkg::COLOR_HEIGHT));
  assign hit_next = s_nz && x_in && y_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    hit     <= hit_next;
    color_x <= (hit_next && !x_neg) ? xi[dtc_pkg::PIX_W-1:0] : '0;
    color_y <= (hit_next && !y_neg) ? yi[dtc_pkg::PIX_W-1:0] : '0;
  end

endmodule

`default_nettype wire

### sv/dtc_chk.sv
// port-level checks of the depth to color pixel map
`timescale 1ns / 1ps
`default_nettype none

module dtc_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [dtc_pkg::MM_W-1:0]      depth_mm,
  input wire logic                          done,
  input wire logic                          hit,
  input wire logic [dtc_pkg::PIX_W-1:0]     color_x,
  input wire logic [dtc_pkg::PIX_W-1:0]     color_y
);

  // every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(dtc_pkg::LATENCY) done)
    else $error("accepted word gave no result at the expected cycle");

  // no result word without a word accepted that long ago
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, dtc_pkg::LATENCY))
    else $error("result word without a matching accepted word");

  // zero depth never hits
  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && depth_mm == '0) |-> ##(dtc_pkg::LATENCY) (done && !hit))
    else $error("zero depth reported a hit");

  // hits stay in the color frame, misses read as zero
  a_frame: assert property (@(posedge clk) disable iff (rst)
    done |-> (hit ? (color_x < dtc_pkg::PIX_W'(dtc_pkg::COLOR_WIDTH) &&
                     color_y < dtc_pkg::PIX_W'(dtc_pkg::COLOR_HEIGHT))
                  : (color_x == '0 && color_y == '0)))
    else $error("result coordinates do not match the hit flag");

endmodule

bind depth_to_color_pixel_map dtc_chk u_chk (.*);

`default_nettype wire
